// ----- src/dmdr_pkg.sv -----
// ----------------------------------------------------------------------------
// Dot-matrix digit renderer package
// Shared constants, the 5x7 font and common types for the renderer blocks.
// ----------------------------------------------------------------------------
package dmdr_pkg;

   localparam int MAX_DIGITS_DEF = 3;

   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_CELLS = GLYPH_COLS * GLYPH_ROWS;
   localparam int DIGIT_PITCH = 6;
   localparam int LEFT_MARGIN = 10;

   localparam int CELL_MIN = 1;
   localparam int CELL_MAX = 64;

   localparam logic [6:0] CELL_RESET = 7'd8;

   localparam int QUEUE_DEPTH = 2;

   typedef logic [GLYPH_CELLS-1:0] glyph_type;
   typedef logic [6:0]             cell_type;

   // Glyph bits run row by row from the top, leftmost column first; the top
   // left cell is the most significant bit.
   function automatic glyph_type font_glyph(input logic [3:0] digit);
      glyph_type g;
      unique case (digit)
         4'd0:    g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         4'd1:    g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         4'd2:    g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
         4'd3:    g = {5'h1F, 5'h02, 5'h04, 5'h0E, 5'h01, 5'h01, 5'h1E};
         4'd4:    g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         4'd5:    g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h01, 5'h1E};
         4'd6:    g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         4'd7:    g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         4'd8:    g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         4'd9:    g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// ----- src/dmdr_fifo.sv -----
// ----------------------------------------------------------------------------
// Renderer work queue
// Small register queue that carries converted numbers from front to back.
// ----------------------------------------------------------------------------
module dmdr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dmdr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above its depth");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wptr_ff == rptr_ff))
      else $error("queue pointers disagree while the queue is empty");

endmodule

// ----- src/dmdr_front.sv -----
// ----------------------------------------------------------------------------
// Renderer front end
// Accepts an item, saturates it and splits it into decimal digits.
// ----------------------------------------------------------------------------
module dmdr_front #(
   parameter int MAX_DIGITS = dmdr_pkg::MAX_DIGITS_DEF,
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
   localparam int QW    = IDX_W + 4 * MAX_DIGITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  logic [9:0]    req_value,
   input  logic [1:0]    req_min_digits,
   output logic          req_full,
   output logic          q_push,
   output logic [QW-1:0] q_data,
   input  logic          q_full
);

   localparam int LIMIT = 10 ** MAX_DIGITS - 1;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type               state_ff, state_in;
   logic [9:0]                    rest_ff, rest_in;
   logic [IDX_W-1:0]              step_ff, step_in;
   logic [IDX_W-1:0]              mind_ff, mind_in;
   logic [IDX_W-1:0]              nat_ff, nat_in;
   logic [IDX_W-1:0]              top_ff, top_in;
   logic [MAX_DIGITS-1:0][3:0]    digits_ff, digits_in;
   logic [17:0]                   prod;
   logic [9:0]                    quot;
   logic [9:0]                    quot10;
   logic [3:0]                    digit;
   logic [IDX_W-1:0]              nat_next;

   assign req_full = (state_ff != F_IDLE);
   assign q_push   = (state_ff == F_PUSH) && !q_full;
   assign q_data   = {top_ff, digits_ff};

   // Division by ten as a multiply by 205/2048, exact for every value below 1029.
   assign prod   = {8'd0, req_value & 10'd0} + ({8'd0, rest_ff} * 18'd205);
   assign quot   = {3'd0, prod[17:11]};
   assign quot10 = {quot[6:0], 3'b000} + {quot[8:0], 1'b0};
   assign digit  = 4'(rest_ff - quot10);

   always_comb begin
      nat_next = nat_ff;
      if (digit != 4'd0) begin
         nat_next = step_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rest_in   = rest_ff;
      step_in   = step_ff;
      mind_in   = mind_ff;
      nat_in    = nat_ff;
      top_in    = top_ff;
      digits_in = digits_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               rest_in = (req_value > 10'(LIMIT)) ? 10'(LIMIT) : req_value;
               if (req_min_digits == 2'd0) begin
                  mind_in = '0;
               end else if (32'(req_min_digits) > MAX_DIGITS) begin
                  mind_in = IDX_W'(MAX_DIGITS - 1);
               end else begin
                  mind_in = IDX_W'(req_min_digits - 2'd1);
               end
               step_in  = '0;
               nat_in   = '0;
               state_in = F_CONV;
            end
         end
         F_CONV: begin
            // Least significant digit first; after the last step the units digit
            // has shifted down to index zero.
            for (int j = 0; j < MAX_DIGITS - 1; j++) begin
               digits_in[j] = digits_ff[j+1];
            end
            digits_in[MAX_DIGITS-1] = digit;
            rest_in = quot;
            nat_in  = nat_next;
            if (step_ff == IDX_W'(MAX_DIGITS - 1)) begin
               top_in   = (nat_next > mind_ff) ? nat_next : mind_ff;
               state_in = F_PUSH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff   <= rest_in;
      step_ff   <= step_in;
      mind_ff   <= mind_in;
      nat_ff    <= nat_in;
      top_ff    <= top_in;
      digits_ff <= digits_in;
   end

   for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_digit_chk
      assert property (@(posedge clock) disable iff (reset) q_push |-> digits_ff[j] <= 4'd9)
         else $error("front end queued a digit above nine");
   end

endmodule

// ----- src/dmdr_back.sv -----
// ----------------------------------------------------------------------------
// Renderer back end
// Scans each queued number's glyphs one cell a cycle, unless a lit cell waits on a full output, and emits lit cells.
// ----------------------------------------------------------------------------
module dmdr_back #(
   parameter int MAX_DIGITS = dmdr_pkg::MAX_DIGITS_DEF,
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1),
   localparam int QW    = IDX_W + 4 * MAX_DIGITS
) (
   input  logic                clock,
   input  logic                reset,
   input  dmdr_pkg::cell_type  cell_size,
   input  logic                q_empty,
   input  logic [QW-1:0]       q_data,
   output logic                q_pop,
   output logic [10:0]         rsp_rect_x,
   output logic [8:0]          rsp_rect_y,
   output logic [6:0]          rsp_rect_size,
   output logic                rsp_first_rect,
   output logic                rsp_last_rect,
   output logic [9:0]          rsp_total_width,
   input  logic                rsp_pop,
   output logic                rsp_empty
);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_SCAN = 2'b10
   } back_state_type;

   back_state_type             state_ff, state_in;
   logic [MAX_DIGITS-1:0][3:0] digits_ff, digits_in;
   logic [IDX_W-1:0]           place_ff, place_in;
   logic [5:0]                 cell_ff, cell_in;
   logic [2:0]                 col_ff, col_in;
   logic [10:0]                x_ff, x_in;
   logic [10:0]                xbase_ff, xbase_in;
   logic [8:0]                 y_ff, y_in;
   logic                       first_ff, first_in;
   logic [9:0]                 width_ff, width_in;
   logic                       out_valid_ff, out_valid_in;
   logic [10:0]                out_x_ff;
   logic [8:0]                 out_y_ff;
   logic [6:0]                 out_size_ff;
   logic                       out_first_ff;
   logic                       out_last_ff;
   logic [9:0]                 out_width_ff;

   logic [IDX_W-1:0]           q_top;
   logic [CNT_W-1:0]           q_ndig;
   logic [8:0]                 digit_w;
   dmdr_pkg::glyph_type        glyph;
   dmdr_pkg::glyph_type        rest_mask;
   logic [5:0]                 bit_pos;
   logic                       lit;
   logic                       last;
   logic                       out_free;
   logic                       emit;
   logic                       scan_end;
   logic [10:0]                step_x;
   logic [10:0]                pitch_x;

   localparam logic [5:0] CELL_LAST = 6'(dmdr_pkg::GLYPH_CELLS - 1);
   localparam logic [2:0] COL_LAST  = 3'(dmdr_pkg::GLYPH_COLS - 1);

   assign q_top   = q_data[QW-1 -: IDX_W];
   assign q_ndig  = CNT_W'(q_top) + 1'b1;
   assign digit_w = {2'b00, cell_size} + {cell_size, 2'b00}
                    + 9'(dmdr_pkg::LEFT_MARGIN);

   assign step_x  = {4'd0, cell_size};
   assign pitch_x = {2'd0, cell_size, 2'b00} + {3'd0, cell_size, 1'b0};

   assign glyph     = dmdr_pkg::font_glyph(digits_ff[place_ff]);
   assign bit_pos   = CELL_LAST - cell_ff;
   assign lit       = glyph[bit_pos];
   assign rest_mask = (dmdr_pkg::glyph_type'(1) << bit_pos) - dmdr_pkg::glyph_type'(1);
   // The final rectangle is the lit cell with nothing lit after it in the last digit.
   assign last      = (place_ff == '0) && ((glyph & rest_mask) == '0);
   assign scan_end  = (place_ff == '0) && (cell_ff == CELL_LAST);

   assign out_free  = !out_valid_ff || rsp_pop;
   assign emit      = (state_ff == B_SCAN) && lit && out_free;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      state_in  = state_ff;
      digits_in = digits_ff;
      place_in  = place_ff;
      cell_in   = cell_ff;
      col_in    = col_ff;
      x_in      = x_ff;
      xbase_in  = xbase_ff;
      y_in      = y_ff;
      first_in  = first_ff;
      width_in  = width_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               digits_in = q_data[4*MAX_DIGITS-1:0];
               place_in  = q_top;
               cell_in   = '0;
               col_in    = '0;
               x_in      = 11'(dmdr_pkg::LEFT_MARGIN);
               xbase_in  = 11'(dmdr_pkg::LEFT_MARGIN);
               y_in      = '0;
               first_in  = 1'b1;
               width_in  = {1'b0, digit_w} * 10'(q_ndig);
               state_in  = B_SCAN;
            end
         end
         B_SCAN: begin
            if (!lit || out_free) begin
               if (emit) begin
                  first_in = 1'b0;
               end
               if (cell_ff == CELL_LAST) begin
                  if (place_ff == '0) begin
                     state_in = B_IDLE;
                  end else begin
                     place_in = place_ff - 1'b1;
                     cell_in  = '0;
                     col_in   = '0;
                     xbase_in = xbase_ff + pitch_x;
                     x_in     = xbase_ff + pitch_x;
                     y_in     = '0;
                  end
               end else begin
                  cell_in = cell_ff + 1'b1;
                  if (col_ff == COL_LAST) begin
                     col_in = '0;
                     x_in   = xbase_ff;
                     y_in   = y_ff + {2'b00, cell_size};
                  end else begin
                     col_in = col_ff + 1'b1;
                     x_in   = x_ff + step_x;
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      place_ff  <= place_in;
      cell_ff   <= cell_in;
      col_ff    <= col_in;
      x_ff      <= x_in;
      xbase_ff  <= xbase_in;
      y_ff      <= y_in;
      first_ff  <= first_in;
      width_ff  <= width_in;
      if (emit) begin
         out_x_ff     <= x_ff;
         out_y_ff     <= y_ff;
         out_size_ff  <= cell_size;
         out_first_ff <= first_ff;
         out_last_ff  <= last;
         out_width_ff <= width_ff;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_rect_x      = out_x_ff;
   assign rsp_rect_y      = out_y_ff;
   assign rsp_rect_size   = out_size_ff;
   assign rsp_first_rect  = out_first_ff;
   assign rsp_last_rect   = out_last_ff;
   assign rsp_total_width = out_width_ff;

   // Every glyph has lit cells, so an item never reaches its final cell with
   // nothing emitted unless that final cell is itself lit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SCAN && scan_end) |-> (!first_ff || lit))
      else $error("scan ended without a rectangle");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_x_ff)
                                      && $stable(out_y_ff) && $stable(out_last_ff)))
      else $error("waiting result changed before it was taken");

endmodule

// ----- src/dot_matrix_digit_rectangle_renderer_core.sv -----
// ----------------------------------------------------------------------------
// Dot-matrix digit rectangle renderer
// Renders a number as 5x7 dot-matrix digits, one square per lit glyph cell.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Direction  Carries
//   req       req_push / req_full                     in         value, min_digits
//   rsp       rsp_pop / rsp_empty                     out        one lit cell rectangle
//   csr       csr_valid / csr_ready                   in         cell_size
//
// The front end takes an item in F_IDLE, converts it one digit per step in F_CONV
// and pushes it to the queue from F_PUSH, which waits while the queue is full; it
// takes no new item until that push is done. The back end sets up an item in B_IDLE
// and then scans every rendered digit in B_SCAN, one glyph cell a cycle.
// A full result register holds the scan on a lit cell until the result is taken.
// Reset is synchronous; it sets cell_size to 8 and empties the queue and the result register.
//
module dot_matrix_digit_rectangle_renderer_core #(
   parameter int MAX_DIGITS = dmdr_pkg::MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [9:0]  req_value,
   input  logic [1:0]  req_min_digits,
   output logic        req_full,
   output logic [10:0] rsp_rect_x,
   output logic [8:0]  rsp_rect_y,
   output logic [6:0]  rsp_rect_size,
   output logic        rsp_first_rect,
   output logic        rsp_last_rect,
   output logic [9:0]  rsp_total_width,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   input  logic        csr_valid,
   input  logic [6:0]  csr_data,
   output logic        csr_ready
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int QW    = IDX_W + 4 * MAX_DIGITS;

   dmdr_pkg::cell_type cell_size_ff, cell_size_in;
   dmdr_pkg::cell_type cell_eff;
   logic               q_push;
   logic [QW-1:0]      q_push_data;
   logic               q_full;
   logic               q_pop;
   logic [QW-1:0]      q_pop_data;
   logic               q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cell_size_in = cell_size_ff;
      if (csr_valid) begin
         cell_size_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= dmdr_pkg::CELL_RESET;
      end else begin
         cell_size_ff <= cell_size_in;
      end
   end

   // Out-of-range sizes are clamped; the clamped size is what gets reported.
   always_comb begin
      if (cell_size_ff < 7'(dmdr_pkg::CELL_MIN)) begin
         cell_eff = 7'(dmdr_pkg::CELL_MIN);
      end else if (cell_size_ff > 7'(dmdr_pkg::CELL_MAX)) begin
         cell_eff = 7'(dmdr_pkg::CELL_MAX);
      end else begin
         cell_eff = cell_size_ff;
      end
   end

   dmdr_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_value      (req_value),
      .req_min_digits (req_min_digits),
      .req_full       (req_full),
      .q_push         (q_push),
      .q_data         (q_push_data),
      .q_full         (q_full)
   );

   dmdr_fifo #(
      .WIDTH (QW),
      .DEPTH (dmdr_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   dmdr_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cell_size       (cell_eff),
      .q_empty         (q_empty),
      .q_data          (q_pop_data),
      .q_pop           (q_pop),
      .rsp_rect_x      (rsp_rect_x),
      .rsp_rect_y      (rsp_rect_y),
      .rsp_rect_size   (rsp_rect_size),
      .rsp_first_rect  (rsp_first_rect),
      .rsp_last_rect   (rsp_last_rect),
      .rsp_total_width (rsp_total_width),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty)
   );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Dot-matrix digit renderer testbench
// Sends numbers through the renderer and compares every lit-cell rectangle
// with a predictor in the scoreboard. The cell size is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int SETTLE_CYCLES  = 35 * dmdr_pkg::MAX_DIGITS_DEF
                                   + dmdr_pkg::MAX_DIGITS_DEF + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 38;
   localparam int PHASE_COUNT    = 8;

   typedef struct packed {
      logic [10:0] x;
      logic [8:0]  y;
      logic [6:0]  size;
      logic        first;
      logic        last;
      logic [9:0]  width;
   } cell_rect_type;

   // Keeps the rectangles still to come, worked out for each accepted number.
   class lit_cell_board;
      cell_rect_type pending_cells[$];
      int unsigned   cell_size;
      int unsigned   numbers_seen;
      int unsigned   cells_checked;
      int unsigned   mismatches;

      function new();
         cell_size     = 32'(dmdr_pkg::CELL_RESET);
         numbers_seen  = 0;
         cells_checked = 0;
         mismatches    = 0;
      endfunction

      // Bit 4 of a row is the leftmost column.
      function logic [4:0] glyph_row(int unsigned digit, int unsigned row);
         logic [34:0] g;
         case (digit)
            0:       g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            1:       g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            2:       g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
            3:       g = {5'h1F, 5'h02, 5'h04, 5'h0E, 5'h01, 5'h01, 5'h1E};
            4:       g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            5:       g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h01, 5'h1E};
            6:       g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            7:       g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8:       g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            default: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
         endcase
         return g[34 - 5 * row -: 5];
      endfunction

      function void render_number(logic [9:0] value, logic [1:0] min_digits);
         int unsigned   ceiling, v, md, cs, ndig, width, t, pos, row, col, cnt;
         int unsigned   digit_at[dmdr_pkg::MAX_DIGITS_DEF];
         logic [4:0]    bits;
         cell_rect_type rect;
         ceiling = 1;
         for (pos = 0; pos < dmdr_pkg::MAX_DIGITS_DEF; pos++)
            ceiling = ceiling * 10;
         ceiling = ceiling - 1;
         v  = (value > ceiling) ? ceiling : value;
         md = (min_digits == 0) ? 1 : min_digits;
         if (md > dmdr_pkg::MAX_DIGITS_DEF)
            md = dmdr_pkg::MAX_DIGITS_DEF;
         cs = cell_size;
         if (cs < dmdr_pkg::CELL_MIN)
            cs = dmdr_pkg::CELL_MIN;
         if (cs > dmdr_pkg::CELL_MAX)
            cs = dmdr_pkg::CELL_MAX;
         ndig = 1;
         t    = v;
         while (t >= 10) begin
            t = t / 10;
            ndig++;
         end
         if (md > ndig)
            ndig = md;
         t = v;
         for (pos = ndig; pos > 0; pos--) begin
            digit_at[pos-1] = t % 10;
            t = t / 10;
         end
         width = (dmdr_pkg::GLYPH_COLS * cs + dmdr_pkg::LEFT_MARGIN) * ndig;
         cnt   = 0;
         for (pos = 0; pos < ndig; pos++) begin
            for (row = 0; row < dmdr_pkg::GLYPH_ROWS; row++) begin
               bits = glyph_row(digit_at[pos], row);
               for (col = 0; col < dmdr_pkg::GLYPH_COLS; col++) begin
                  if (bits[dmdr_pkg::GLYPH_COLS-1-col]) begin
                     rect.x     = 11'(dmdr_pkg::LEFT_MARGIN
                                      + (pos * dmdr_pkg::DIGIT_PITCH + col) * cs);
                     rect.y     = 9'(row * cs);
                     rect.size  = 7'(cs);
                     rect.first = (cnt == 0);
                     rect.last  = 1'b0;
                     rect.width = 10'(width);
                     pending_cells.push_back(rect);
                     cnt++;
                  end
               end
            end
         end
         // Every glyph has a lit cell, so the number always leaves one behind.
         pending_cells[pending_cells.size()-1].last = 1'b1;
         numbers_seen++;
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_field(string name, logic [10:0] got, logic [10:0] want);
         if (got !== want)
            report($sformatf("rectangle %0d: %s is %0d, expected %0d",
                             cells_checked, name, got, want));
      endtask

      task compare_cell(cell_rect_type got);
         cell_rect_type want;
         if (pending_cells.size() == 0) begin
            report($sformatf("rectangle at x=%0d y=%0d arrived with none expected",
                             got.x, got.y));
         end else begin
            want = pending_cells.pop_front();
            check_field("rect_x", got.x, want.x);
            check_field("rect_y", 11'(got.y), 11'(want.y));
            check_field("rect_size", 11'(got.size), 11'(want.size));
            check_field("first_rect", 11'(got.first), 11'(want.first));
            check_field("last_rect", 11'(got.last), 11'(want.last));
            check_field("total_width", 11'(got.width), 11'(want.width));
            cells_checked++;
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_push;
   logic [9:0]         req_value;
   logic [1:0]         req_min_digits;
   logic               req_full;
   logic [10:0]        rsp_rect_x;
   logic [8:0]         rsp_rect_y;
   logic [6:0]         rsp_rect_size;
   logic               rsp_first_rect;
   logic               rsp_last_rect;
   logic [9:0]         rsp_total_width;
   logic               rsp_pop;
   logic               rsp_empty;
   logic               csr_valid;
   dmdr_pkg::cell_type csr_data;
   logic               csr_ready;

   lit_cell_board board;
   int unsigned   idle_odds;
   int unsigned   quiet_cycles;
   int unsigned   size_writes;

   dot_matrix_digit_rectangle_renderer_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_value       (req_value),
      .req_min_digits  (req_min_digits),
      .req_full        (req_full),
      .rsp_rect_x      (rsp_rect_x),
      .rsp_rect_y      (rsp_rect_y),
      .rsp_rect_size   (rsp_rect_size),
      .rsp_first_rect  (rsp_first_rect),
      .rsp_last_rect   (rsp_last_rect),
      .rsp_total_width (rsp_total_width),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .csr_ready       (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Observes all three channels on the rising edge and keeps the watchdog.
   always @(posedge clock) begin : observe
      cell_rect_type got;
      logic          moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            board.cell_size = 32'(csr_data);
            size_writes++;
            moved = 1'b1;
         end
         if (req_push && !req_full) begin
            board.render_number(req_value, req_min_digits);
            moved = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_rect_x, rsp_rect_y, rsp_rect_size, rsp_first_rect,
                   rsp_last_rect, rsp_total_width};
            board.compare_cell(got);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // The receiver stalls in bursts while idling is allowed.
   initial begin : pop_driver
      int unsigned hold;
      hold = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, 4 * idle_odds) == 1) begin
            hold = $urandom_range(1, 17) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Called at a falling edge; leaves push high with the item just taken, so
   // the caller must drive a new item or lower push at the next falling edge.
   task automatic send_number(logic [9:0] value, logic [1:0] min_digits);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_push       <= 1'b1;
      req_value      <= value;
      req_min_digits <= min_digits;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (board.pending_cells.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_cell_size(dmdr_pkg::cell_type size_value);
      drain_results();
      // The scan may still be passing unlit cells after the last rectangle.
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= size_value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [9:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 10'($urandom_range(0, 9));
         1:       return 10'($urandom_range(1000, 1023));
         2:       return 10'($urandom_range(0, 1023));
         3:       return 10'($urandom_range(10, 99));
         default: return 10'($urandom_range(0, 999));
      endcase
   endfunction

   initial begin : stimulus
      dmdr_pkg::cell_type phase_size;
      int                 phase;
      int                 n;
      board        = new();
      idle_odds    = 4;
      quiet_cycles = 0;
      size_writes  = 0;
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_value      <= '0;
      req_min_digits <= '0;
      csr_valid      <= 1'b0;
      csr_data       <= '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset cell size first: every digit, every minimum, saturation and padding.
      send_number(10'd0, 2'd1);
      send_number(10'd999, 2'd3);
      send_number(10'd1023, 2'd0);
      send_number(10'd1000, 2'd2);
      send_number(10'd7, 2'd3);
      send_number(10'd5, 2'd0);
      send_number(10'd42, 2'd1);
      send_number(10'd100, 2'd2);
      send_number(10'd9, 2'd2);
      send_number(10'd10, 2'd1);
      send_number(10'd123, 2'd1);
      send_number(10'd456, 2'd3);
      send_number(10'd789, 2'd2);
      send_number(10'd68, 2'd3);
      send_number(10'd512, 2'd3);
      // A zero cell size is used as one.
      write_cell_size(7'd0);
      send_number(10'd888, 2'd3);
      send_number(10'd0, 2'd3);
      // The largest size with three zeros gives the most rectangles and the
      // widest coordinates; 127 is used as 64.
      write_cell_size(7'd127);
      send_number(10'd0, 2'd3);
      send_number(10'd1023, 2'd3);
      write_cell_size(7'd65);
      send_number(10'd808, 2'd1);
      write_cell_size(7'd1);
      send_number(10'd1, 2'd0);
      send_number(10'd640, 2'd1);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       phase_size = 7'd64;
            1:       phase_size = 7'($urandom_range(2, 63));
            2:       phase_size = 7'd1;
            3:       phase_size = 7'd65;
            4:       phase_size = 7'($urandom_range(0, 127));
            5:       phase_size = 7'd8;
            6:       phase_size = 7'($urandom_range(2, 63));
            default: phase_size = 7'($urandom_range(2, 63));
         endcase
         case (phase)
            0:       idle_odds = 4;
            1:       idle_odds = 0;
            2:       idle_odds = 3;
            3:       idle_odds = 8;
            4:       idle_odds = 2;
            5:       idle_odds = 5;
            6:       idle_odds = 3;
            default: idle_odds = 0;
         endcase
         write_cell_size(phase_size);
         for (n = 0; n < PHASE_ITEMS; n++)
            send_number(pick_value(), 2'($urandom_range(0, 3)));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (board.pending_cells.size() != 0)
         board.report("rectangle still expected at the end of the run");
      $display("Rendered %0d numbers over %0d cell size settings; %0d rectangles checked.",
               board.numbers_seen, size_writes + 1, board.cells_checked);
      if (board.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches found.", board.mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
